### rtl/isce_pkg.sv
// Shared types and helper functions for the isolated superpixel cluster encoder.
// Depends on nothing; used by the top level and the output stage.
package isce_pkg;

   localparam int unsigned GROW_STEPS_PER_STAGE = 4;

   typedef struct packed {
      logic [2:0] sc;
      logic [3:0] sr;
      logic [3:0] n;
   } sums_type;

   typedef struct packed {
      logic [9:0] pixel_col;
      logic [2:0] col_eighths;
      logic [7:0] pixel_row;
      logic [2:0] row_eighths;
   } res_type;

   // One step of 8-connected dilation inside the 2x4 superpixel
   function automatic logic [7:0] grow_mask(input logic [7:0] m);
      logic [7:0] v;
      v = m | ((m << 1) & 8'hEE) | ((m >> 1) & 8'h77);
      return v | (v << 4) | (v >> 4);
   endfunction

   function automatic sums_type cluster_sums(input logic [7:0] comp);
      sums_type s;
      s = '0;
      for (int i = 0; i < 8; i++) begin
         if (comp[i]) begin
            s.sc = s.sc + 3'(i >> 2);
            s.sr = s.sr + 4'(i & 3);
            s.n  = s.n + 4'd1;
         end
      end
      return s;
   endfunction

   // ceil(4096 / n); exact floor division for dividends up to 96
   function automatic logic [12:0] recip_q12(input logic [3:0] n);
      logic [12:0] r;
      case (n)
         4'd1:    r = 13'd4096;
         4'd2:    r = 13'd2048;
         4'd3:    r = 13'd1366;
         4'd4:    r = 13'd1024;
         4'd5:    r = 13'd820;
         4'd6:    r = 13'd683;
         4'd7:    r = 13'd586;
         4'd8:    r = 13'd512;
         default: r = 13'd4096;
      endcase
      return r;
   endfunction

   // floor(8 * sum / n)
   function automatic logic [6:0] eighths(input logic [3:0] sum, input logic [3:0] n);
      logic [19:0] p;
      p = 20'({sum, 3'b000}) * 20'(recip_q12(n));
      return p[18:12];
   endfunction

endpackage

### rtl/isce_out_stage.sv
// Output register of the encoder: holds both cluster results of one superpixel
// and hands them out one word at a time. Depends on isce_pkg.
module isce_out_stage import isce_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       load_valid,
   input  logic       load_two,
   input  res_type    load_res_a,
   input  res_type    load_res_b,
   output logic       load_ready,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [9:0] rsp_pixel_col,
   output logic [2:0] rsp_col_eighths,
   output logic [7:0] rsp_pixel_row,
   output logic [2:0] rsp_row_eighths,
   output logic       rsp_last
);

   logic    valid_ff;
   logic    two_ff;
   logic    phase_ff;
   res_type res_a_ff;
   res_type res_b_ff;
   res_type cur;
   logic    final_word;
   logic    rsp_take;

   assign final_word = phase_ff || !two_ff;
   assign rsp_take   = valid_ff && !rsp_stall;
   assign load_ready = !valid_ff || (rsp_take && final_word);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else if (load_ready) begin
         valid_ff <= load_valid;
         phase_ff <= 1'b0;
      end else if (rsp_take) begin
         // first of two words gone, advance to the second
         phase_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (load_ready) begin
         two_ff   <= load_two;
         res_a_ff <= load_res_a;
         res_b_ff <= load_res_b;
      end
   end

   assign cur             = phase_ff ? res_b_ff : res_a_ff;
   assign rsp_valid       = valid_ff;
   assign rsp_pixel_col   = cur.pixel_col;
   assign rsp_col_eighths = cur.col_eighths;
   assign rsp_pixel_row   = cur.pixel_row;
   assign rsp_row_eighths = cur.row_eighths;
   assign rsp_last        = final_word;

endmodule

### rtl/isolated_superpixel_cluster_encoder.sv
// Throughput: one superpixel per cycle with one cluster while rsp_stall is low.
// With two clusters the output stage hands out both results of a superpixel in turn
// and takes the next superpixel only once the second word has gone.
// Pipeline: dilation (two stages of four steps), cluster sums, centroid and output.
// Reset: synchronous, clears all stage valid bits and the output phase; data registers are not reset.
// Top level; depends on isce_pkg and isce_out_stage.
module isolated_superpixel_cluster_encoder import isce_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_hit_pattern,
   input  logic [5:0] req_super_row,
   input  logic [8:0] req_super_col,
   input  logic       req_isolated,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [9:0] rsp_pixel_col,
   output logic [2:0] rsp_col_eighths,
   output logic [7:0] rsp_pixel_row,
   output logic [2:0] rsp_row_eighths,
   output logic       rsp_last
);

   // stage 1: seed and first half of the dilation
   logic       s1_valid_ff;
   logic [7:0] s1_pattern_ff, s1_comp_ff, s1_comp_in;
   logic [5:0] s1_srow_ff;
   logic [8:0] s1_scol_ff;
   // stage 2: finished first cluster and remainder
   logic       s2_valid_ff;
   logic [7:0] s2_c1_ff, s2_c1_in, s2_rest_ff;
   logic [5:0] s2_srow_ff;
   logic [8:0] s2_scol_ff;
   // stage 3: per-cluster sums
   logic       s3_valid_ff;
   logic       s3_two_ff;
   sums_type   s3_a_ff, s3_b_ff;
   logic [5:0] s3_srow_ff;
   logic [8:0] s3_scol_ff;

   logic       out_ready, s3_ready, s2_ready, s1_ready;
   res_type    res_a_in, res_b_in;

   assign s3_ready  = !s3_valid_ff || out_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_stall = !s1_ready;

   always_comb begin
      s1_comp_in = req_hit_pattern & (~req_hit_pattern + 8'd1);
      for (int k = 0; k < GROW_STEPS_PER_STAGE; k++)
         s1_comp_in = grow_mask(s1_comp_in) & req_hit_pattern;
   end

   always_comb begin
      s2_c1_in = s1_comp_ff;
      for (int k = 0; k < GROW_STEPS_PER_STAGE; k++)
         s2_c1_in = grow_mask(s2_c1_in) & s1_pattern_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         // drop empty and non-isolated words at the door
         if (s1_ready) s1_valid_ff <= req_valid && req_isolated && (req_hit_pattern != 8'd0);
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
         if (s3_ready) s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_pattern_ff <= req_hit_pattern;
         s1_comp_ff    <= s1_comp_in;
         s1_srow_ff    <= req_super_row;
         s1_scol_ff    <= req_super_col;
      end
      if (s2_ready) begin
         s2_c1_ff   <= s2_c1_in;
         s2_rest_ff <= s1_pattern_ff & ~s2_c1_in;
         s2_srow_ff <= s1_srow_ff;
         s2_scol_ff <= s1_scol_ff;
      end
      if (s3_ready) begin
         s3_two_ff  <= (s2_rest_ff != 8'd0);
         s3_a_ff    <= cluster_sums(s2_c1_ff);
         s3_b_ff    <= cluster_sums(s2_rest_ff);
         s3_srow_ff <= s2_srow_ff;
         s3_scol_ff <= s2_scol_ff;
      end
   end

   // centroid in eighths, split into integer offset and fraction
   function automatic res_type make_res(input sums_type s, input logic [5:0] srow,
                                        input logic [8:0] scol);
      logic [6:0] c8;
      logic [6:0] r8;
      res_type    r;
      c8 = eighths({1'b0, s.sc}, s.n);
      r8 = eighths(s.sr, s.n);
      r.pixel_col   = {scol, 1'b0} + 10'(c8[6:3]);
      r.col_eighths = c8[2:0];
      r.pixel_row   = {srow, 2'b00} + 8'(r8[6:3]);
      r.row_eighths = r8[2:0];
      return r;
   endfunction

   assign res_a_in = make_res(s3_a_ff, s3_srow_ff, s3_scol_ff);
   assign res_b_in = make_res(s3_b_ff, s3_srow_ff, s3_scol_ff);

   isce_out_stage u_out (
      .clock           (clock),
      .reset           (reset),
      .load_valid      (s3_valid_ff),
      .load_two        (s3_two_ff),
      .load_res_a      (res_a_in),
      .load_res_b      (res_b_in),
      .load_ready      (out_ready),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_col   (rsp_pixel_col),
      .rsp_col_eighths (rsp_col_eighths),
      .rsp_pixel_row   (rsp_pixel_row),
      .rsp_row_eighths (rsp_row_eighths),
      .rsp_last        (rsp_last)
   );

endmodule

### rtl/isce_checker.sv
// Port-level checks for the isolated superpixel cluster encoder, bound to the top.
// Depends only on the top level's ports.
module isce_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [7:0] req_hit_pattern,
   input logic [5:0] req_super_row,
   input logic [8:0] req_super_col,
   input logic       req_isolated,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [9:0] rsp_pixel_col,
   input logic [2:0] rsp_col_eighths,
   input logic [7:0] rsp_pixel_row,
   input logic [2:0] rsp_row_eighths,
   input logic       rsp_last
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_valid_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result word withdrawn while stalled");

   a_word_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_pixel_col) && $stable(rsp_pixel_row)
         && $stable(rsp_col_eighths) && $stable(rsp_row_eighths) && $stable(rsp_last))
      else $error("stalled result word changed");

   // second cluster is already held when the first one leaves
   a_second_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=> rsp_valid && rsp_last)
      else $error("second cluster word not ready");

   // column sum is at most four and never exceeds the pixel count, so seven eighths cannot occur
   a_col_fraction: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_col_eighths != 3'd7)
      else $error("impossible column fraction");

endmodule

bind isolated_superpixel_cluster_encoder isce_checker u_isce_checker (.*);
